// File: rtl/bsit_pkg.sv
// Shared types and constants of the best scoring interval trim block.
// Depends on nothing; the other files of the block but the input channel use it.
package bsit_pkg;

    // Width of all scores and of the configuration registers.
    localparam int SCORE_W   = 24;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_SCORE      = 2'd0,
        CFG_MISMATCH_PENALTY = 2'd1,
        CFG_END_BONUS        = 2'd2
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_W-1:0] match_score;
        logic [CFG_W-1:0] mismatch_penalty;
        logic [CFG_W-1:0] end_bonus;
    } t_cfg;

    // Classification flags of one queued item.
    typedef struct packed {
        logic first_item;
        logic last_item;
        logic start_full;
        logic end_full;
    } t_item_flags;

endpackage

// File: rtl/bsit_in_if.sv
// Input channel of the trim block: one mismatch item per handshake.
// Depends on nothing else.
interface bsit_in_if #(
    parameter int POS_BITS = 16
) ();
    logic                valid;
    logic                ready;
    logic [POS_BITS-1:0] read_start;
    logic [POS_BITS-1:0] read_end;
    logic                start_full;
    logic                end_full;
    logic [POS_BITS-1:0] mismatch_pos;
    logic                first_item;
    logic                last_item;

    modport source (
        output valid, read_start, read_end, start_full, end_full,
               mismatch_pos, first_item, last_item,
        input  ready
    );

    modport sink (
        input  valid, read_start, read_end, start_full, end_full,
               mismatch_pos, first_item, last_item,
        output ready
    );
endinterface

// File: rtl/bsit_out_if.sv
// Output channel of the trim block: one trimmed interval per handshake.
// Depends on bsit_pkg for the score width.
interface bsit_out_if #(
    parameter int POS_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic [POS_BITS-1:0]          best_start;
    logic [POS_BITS-1:0]          best_end;
    logic [bsit_pkg::SCORE_W-1:0] best_sum;
    logic                         trimmed;
    logic                         emptied;
    logic                         start_full_out;
    logic                         end_full_out;

    modport source (
        output valid, best_start, best_end, best_sum, trimmed, emptied,
               start_full_out, end_full_out,
        input  ready
    );

    modport sink (
        input  valid, best_start, best_end, best_sum, trimmed, emptied,
               start_full_out, end_full_out,
        output ready
    );
endinterface

// File: rtl/bsit_front.sv
// Front end of the trim block: accepts items and queues them with their flags.
// Depends on bsit_pkg and bsit_in_if.
module bsit_front #(
    parameter int POS_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bsit_in_if.sink                i_in,
    output logic                   o_q_valid,
    output logic [POS_BITS-1:0]    o_q_read_start,
    output logic [POS_BITS-1:0]    o_q_read_end,
    output logic [POS_BITS-1:0]    o_q_mismatch_pos,
    output bsit_pkg::t_item_flags  o_q_flags,
    input  logic                   i_q_pop
);
    import bsit_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    logic [POS_BITS-1:0] r_q_rs [Q_DEPTH];
    logic [POS_BITS-1:0] r_q_re [Q_DEPTH];
    logic [POS_BITS-1:0] r_q_m  [Q_DEPTH];
    t_item_flags         r_q_fl [Q_DEPTH];
    logic [Q_AW-1:0]     r_wr_ptr;
    logic [Q_AW-1:0]     r_rd_ptr;
    logic [Q_CW-1:0]     r_count;
    logic                push;
    logic                pop;
    t_item_flags         in_flags;

    // Classify the incoming item.
    always_comb begin
        in_flags.first_item = i_in.first_item;
        in_flags.last_item  = i_in.last_item;
        in_flags.start_full = i_in.start_full;
        in_flags.end_full   = i_in.end_full;
    end

    assign i_in.ready = (r_count < Q_CW'(Q_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_rs[r_wr_ptr] <= i_in.read_start;
            r_q_re[r_wr_ptr] <= i_in.read_end;
            r_q_m[r_wr_ptr]  <= i_in.mismatch_pos;
            r_q_fl[r_wr_ptr] <= in_flags;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_q_read_start   = r_q_rs[r_rd_ptr];
    assign o_q_read_end     = r_q_re[r_rd_ptr];
    assign o_q_mismatch_pos = r_q_m[r_rd_ptr];
    assign o_q_flags        = r_q_fl[r_rd_ptr];

endmodule

// File: rtl/bsit_back.sv
// Back end of the trim block: running interval update, closing stage and
// result register. Depends on bsit_pkg and bsit_out_if.
module bsit_back #(
    parameter int POS_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bsit_pkg::t_cfg         i_cfg,
    input  logic                   i_q_valid,
    input  logic [POS_BITS-1:0]    i_q_read_start,
    input  logic [POS_BITS-1:0]    i_q_read_end,
    input  logic [POS_BITS-1:0]    i_q_mismatch_pos,
    input  bsit_pkg::t_item_flags  i_q_flags,
    output logic                   o_q_pop,
    bsit_out_if.source             o_out
);
    import bsit_pkg::*;

    localparam int PROD_W = POS_BITS + CFG_W;
    localparam int SUM_W  = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Clamp a widened sum to the score range.
    function automatic logic [SCORE_W-1:0] sat_fit(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(SCORE_MAX)) ? SCORE_MAX : v[SCORE_W-1:0];
    endfunction

    // Length of an interval; a reversed interval has length zero.
    function automatic logic [POS_BITS-1:0] span_len(input logic [POS_BITS-1:0] lo,
                                                     input logic [POS_BITS-1:0] hi);
        return (hi > lo) ? hi - lo : '0;
    endfunction

    // Running state.
    logic [POS_BITS-1:0] r_cur_start, r_cur_end, r_best_lo, r_best_hi;
    logic [SCORE_W-1:0]  r_cur_score, r_best_total;

    // Closing stage snapshot.
    logic                r_t_valid;
    logic [POS_BITS-1:0] r_t_cur_start, r_t_cur_end, r_t_best_lo, r_t_best_hi;
    logic [SCORE_W-1:0]  r_t_cur_score, r_t_best_total;
    logic [POS_BITS-1:0] r_t_rs, r_t_re;
    logic                r_t_lf, r_t_rf;

    // Result register.
    logic                r_o_valid;
    logic [POS_BITS-1:0] r_o_start, r_o_end;
    logic [SCORE_W-1:0]  r_o_score;
    logic                r_o_trimmed, r_o_emptied, r_o_lf, r_o_rf;

    // Update stage signals.
    logic                go, t_fire;
    logic [POS_BITS-1:0] s_start, s_end, s_diff, e_end;
    logic [SCORE_W-1:0]  s_score, e_score;
    logic [PROD_W-1:0]   s_prod;
    logic                s_run, s_better;
    logic [POS_BITS-1:0] n_cur_start, n_cur_end, n_best_lo, n_best_hi;
    logic [SCORE_W-1:0]  n_cur_score, n_best_total;

    // Closing stage signals.
    logic [POS_BITS-1:0] t_diff, t_e_end;
    logic [PROD_W-1:0]   t_prod;
    logic                t_run, t_better;
    logic [SCORE_W-1:0]  t_e_score, t_f_score;
    logic [POS_BITS-1:0] t_b_lo, t_b_hi;
    logic [SCORE_W-1:0]  t_b_total;
    logic                t_same, t_empty;
    logic [SCORE_W-1:0]  t_o_score;
    logic                t_o_trimmed, t_o_emptied, t_o_lf, t_o_rf;

    // The closing stage hands its result on when the result register frees up.
    assign t_fire = r_t_valid && (!r_o_valid || o_out.ready);
    // A first item overwrites all state, so it may pass a finishing closing stage.
    assign go = i_q_valid && (!r_t_valid || (t_fire && i_q_flags.first_item));
    assign o_q_pop = go;

    // Update stage: extend the run to the mismatch, track best, then keep or restart.
    always_comb begin
        s_start = i_q_flags.first_item ? i_q_read_start : r_cur_start;
        s_end   = i_q_flags.first_item ? i_q_read_start : r_cur_end;
        if (i_q_flags.first_item) begin
            s_score = i_q_flags.start_full ? SCORE_W'(i_cfg.end_bonus) : '0;
        end else begin
            s_score = r_cur_score;
        end
        s_run  = i_q_mismatch_pos > s_end;
        s_diff = i_q_mismatch_pos - s_end;
        s_prod = PROD_W'(s_diff) * PROD_W'(i_cfg.match_score);
        e_score = s_run ? sat_fit(SUM_W'(s_score) + SUM_W'(s_prod)) : s_score;
        e_end   = s_run ? i_q_mismatch_pos : s_end;

        s_better = (e_score > r_best_total) ||
                   ((e_score == r_best_total) &&
                    (span_len(s_start, e_end) > span_len(r_best_lo, r_best_hi)));
        if (i_q_flags.first_item || s_better) begin
            n_best_lo    = s_start;
            n_best_hi    = e_end;
            n_best_total = e_score;
        end else begin
            n_best_lo    = r_best_lo;
            n_best_hi    = r_best_hi;
            n_best_total = r_best_total;
        end

        if (e_score >= SCORE_W'(i_cfg.mismatch_penalty)) begin
            n_cur_start = s_start;
            n_cur_end   = (e_end < POS_MAX) ? e_end + 1'b1 : e_end;
            n_cur_score = e_score - SCORE_W'(i_cfg.mismatch_penalty);
        end else begin
            n_cur_start = (i_q_mismatch_pos < POS_MAX) ? i_q_mismatch_pos + 1'b1 : POS_MAX;
            n_cur_end   = n_cur_start;
            n_cur_score = '0;
        end
    end

    // Closing stage: run to the read end, right bonus, final best and result fields.
    always_comb begin
        t_run     = r_t_re > r_t_cur_end;
        t_diff    = r_t_re - r_t_cur_end;
        t_prod    = PROD_W'(t_diff) * PROD_W'(i_cfg.match_score);
        t_e_score = t_run ? sat_fit(SUM_W'(r_t_cur_score) + SUM_W'(t_prod)) : r_t_cur_score;
        t_e_end   = t_run ? r_t_re : r_t_cur_end;
        t_f_score = r_t_rf ? sat_fit(SUM_W'(t_e_score) + SUM_W'(i_cfg.end_bonus))
                           : t_e_score;

        t_better = (t_f_score > r_t_best_total) ||
                   ((t_f_score == r_t_best_total) &&
                    (span_len(r_t_cur_start, t_e_end) > span_len(r_t_best_lo, r_t_best_hi)));
        t_b_lo    = t_better ? r_t_cur_start : r_t_best_lo;
        t_b_hi    = t_better ? t_e_end : r_t_best_hi;
        t_b_total = t_better ? t_f_score : r_t_best_total;

        t_same  = (t_b_lo == r_t_rs) && (t_b_hi == r_t_re);
        t_empty = (span_len(t_b_lo, t_b_hi) == '0);
        t_o_score   = t_b_total;
        t_o_trimmed = 1'b0;
        t_o_emptied = 1'b0;
        t_o_lf      = r_t_lf;
        t_o_rf      = r_t_rf;
        if (t_same) begin
            // Interval untouched: flags pass through.
        end else if (t_empty) begin
            t_o_trimmed = 1'b1;
            t_o_emptied = 1'b1;
            t_o_score   = '0;
            t_o_lf      = 1'b0;
            t_o_rf      = 1'b0;
        end else begin
            t_o_trimmed = 1'b1;
            if (t_b_lo > r_t_rs) begin
                t_o_lf = 1'b0;
            end
            if (t_b_hi < r_t_re) begin
                t_o_rf = 1'b0;
            end
        end
    end

    // Running state registers; a first item wins over the closing write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_start  <= '0;
            r_cur_end    <= '0;
            r_cur_score  <= '0;
            r_best_lo    <= '0;
            r_best_hi    <= '0;
            r_best_total <= '0;
        end else if (go) begin
            r_cur_start  <= n_cur_start;
            r_cur_end    <= n_cur_end;
            r_cur_score  <= n_cur_score;
            r_best_lo    <= n_best_lo;
            r_best_hi    <= n_best_hi;
            r_best_total <= n_best_total;
        end else if (t_fire) begin
            r_cur_end    <= t_e_end;
            r_cur_score  <= t_f_score;
            r_best_lo    <= t_b_lo;
            r_best_hi    <= t_b_hi;
            r_best_total <= t_b_total;
        end
    end

    // Closing stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (go && i_q_flags.last_item) begin
            r_t_valid <= 1'b1;
        end else if (t_fire) begin
            r_t_valid <= 1'b0;
        end
    end

    // Closing stage snapshot payload.
    always_ff @(posedge i_clk) begin
        if (go && i_q_flags.last_item) begin
            r_t_cur_start  <= n_cur_start;
            r_t_cur_end    <= n_cur_end;
            r_t_cur_score  <= n_cur_score;
            r_t_best_lo    <= n_best_lo;
            r_t_best_hi    <= n_best_hi;
            r_t_best_total <= n_best_total;
            r_t_rs         <= i_q_read_start;
            r_t_re         <= i_q_read_end;
            r_t_lf         <= i_q_flags.start_full;
            r_t_rf         <= i_q_flags.end_full;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (t_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (t_fire) begin
            r_o_start   <= t_b_lo;
            r_o_end     <= t_b_hi;
            r_o_score   <= t_o_score;
            r_o_trimmed <= t_o_trimmed;
            r_o_emptied <= t_o_emptied;
            r_o_lf      <= t_o_lf;
            r_o_rf      <= t_o_rf;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.best_start     = r_o_start;
    assign o_out.best_end       = r_o_end;
    assign o_out.best_sum       = r_o_score;
    assign o_out.trimmed        = r_o_trimmed;
    assign o_out.emptied        = r_o_emptied;
    assign o_out.start_full_out = r_o_lf;
    assign o_out.end_full_out   = r_o_rf;

endmodule

// File: rtl/best_scoring_interval_trim_core.sv
// Top level of the best scoring interval trim block: configuration registers,
// front queue and back end. Depends on bsit_pkg, bsit_in_if, bsit_out_if,
// bsit_front and bsit_back.
//
// Usage:
// The input channel carries the mismatch positions of one extension, one
// item each, in rising order; the first and last items of an extension are
// flagged. Every item also carries the read interval and the full flags.
// The output channel carries one result per last item: the best scoring
// interval, its score and the trimmed, emptied and new full flags.
// Three 8-bit registers (match score, mismatch penalty, full-length bonus)
// are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write
// them only while idle; the block does not enforce it. One item is taken per
// cycle, except that an item that follows a last item without being a first
// item waits for the closing stage to write back its running state. A result
// passes the closing stage into the result register and stays there until the
// receiver takes it. A stalled receiver holds the result; a two-entry queue and
// the closing stage keep taking items until they fill. Reset clears the queue,
// the running interval and score, and sets the registers to 1, 4 and 5.
module best_scoring_interval_trim_core #(
    parameter int POS_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsit_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsit_pkg::CFG_W-1:0]     i_cfg_data,
    bsit_in_if.sink                        i_in,
    bsit_out_if.source                     o_out
);
    import bsit_pkg::*;

    t_cfg                r_cfg;
    logic                q_valid;
    logic [POS_BITS-1:0] q_read_start;
    logic [POS_BITS-1:0] q_read_end;
    logic [POS_BITS-1:0] q_mismatch_pos;
    t_item_flags         q_flags;
    logic                q_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_score      <= CFG_W'(1);
            r_cfg.mismatch_penalty <= CFG_W'(4);
            r_cfg.end_bonus        <= CFG_W'(5);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MATCH_SCORE:      r_cfg.match_score      <= i_cfg_data;
                CFG_MISMATCH_PENALTY: r_cfg.mismatch_penalty <= i_cfg_data;
                CFG_END_BONUS:        r_cfg.end_bonus        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bsit_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (i_in),
        .o_q_valid        (q_valid),
        .o_q_read_start   (q_read_start),
        .o_q_read_end     (q_read_end),
        .o_q_mismatch_pos (q_mismatch_pos),
        .o_q_flags        (q_flags),
        .i_q_pop          (q_pop)
    );

    bsit_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (q_valid),
        .i_q_read_start   (q_read_start),
        .i_q_read_end     (q_read_end),
        .i_q_mismatch_pos (q_mismatch_pos),
        .i_q_flags        (q_flags),
        .o_q_pop          (q_pop),
        .o_out            (o_out)
    );

endmodule

// File: tb/best_scoring_interval_trim_core_test.sv
// Self-checking testbench of the best scoring interval trim block.
// Depends on bsit_pkg, bsit_in_if, bsit_out_if and best_scoring_interval_trim_core.
// A local interval scorer predicts every trimmed result and checks it field by field.
module best_scoring_interval_trim_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsit_pkg::*;

    localparam int              POS_W         = 16;
    localparam int unsigned     POS_TOP       = 2 ** POS_W - 1;
    localparam longint unsigned SCORE_TOP     = SCORE_MAX;
    localparam int              SETTLE_CYCLES = 8;
    localparam int              DRAIN_CYCLES  = 20;
    localparam int              CYCLE_LIMIT   = 200000;
    localparam int              PRINT_LIMIT   = 50;

    // Ways in which a random extension may be malformed.
    typedef enum int {
        FLAW_NONE,
        FLAW_NO_FIRST,
        FLAW_NO_LAST,
        FLAW_REVERSED,
        FLAW_SHIFTED_READ
    } t_flaw;

    typedef struct {
        logic [POS_W-1:0] read_start;
        logic [POS_W-1:0] read_end;
        logic             start_full;
        logic             end_full;
        logic [POS_W-1:0] mismatch_pos;
        logic             first_item;
        logic             last_item;
    } t_mismatch_item;

    typedef struct {
        logic [POS_W-1:0]   best_start;
        logic [POS_W-1:0]   best_end;
        logic [SCORE_W-1:0] best_sum;
        logic               trimmed;
        logic               emptied;
        logic               start_full_out;
        logic               end_full_out;
    } t_trim_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    bsit_in_if  #(.POS_BITS(POS_W)) in_ch ();
    bsit_out_if #(.POS_BITS(POS_W)) out_ch ();

    best_scoring_interval_trim_core #(.POS_BITS(POS_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Scorer weights and running state, mirroring the block after reset.
    longint unsigned w_match   = 1;
    longint unsigned w_penalty = 4;
    longint unsigned w_bonus   = 5;
    longint unsigned run_lo    = 0;
    longint unsigned run_hi    = 0;
    longint unsigned run_score = 0;
    longint unsigned top_lo    = 0;
    longint unsigned top_hi    = 0;
    longint unsigned top_score = 0;

    t_trim_result expected_trims[$];

    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int errors          = 0;
    int items_sent      = 0;
    int trims_checked   = 0;
    int trims_cut       = 0;
    int trims_emptied   = 0;
    int weight_sets     = 0;
    int cycle_count     = 0;

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned clip_score(input longint unsigned s);
        return (s > SCORE_TOP) ? SCORE_TOP : s;
    endfunction

    function automatic longint unsigned run_length(input longint unsigned lo,
                                                   input longint unsigned hi);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // A run of matches up to target; the end never moves back.
    function automatic void extend_to(input longint unsigned target);
        if (target > run_hi) begin
            run_score = clip_score(run_score + (target - run_hi) * w_match);
            run_hi    = target;
        end
    endfunction

    // The running interval replaces the best one on a higher score, or on a
    // tie when it is longer.
    function automatic void promote_if_better();
        if (run_score > top_score ||
            (run_score == top_score &&
             run_length(run_lo, run_hi) > run_length(top_lo, top_hi))) begin
            top_lo    = run_lo;
            top_hi    = run_hi;
            top_score = run_score;
        end
    endfunction

    // Advance the scorer by one accepted item and queue the trimmed interval
    // that a last item produces.
    task automatic score_item(input t_mismatch_item it);
        longint unsigned rs;
        longint unsigned re;
        longint unsigned pos;
        longint unsigned restart;
        t_trim_result    res;
        rs  = it.read_start;
        re  = it.read_end;
        pos = it.mismatch_pos;
        if (it.first_item) begin
            run_lo    = rs;
            run_hi    = rs;
            run_score = it.start_full ? w_bonus : 0;
            extend_to(pos);
            top_lo    = run_lo;
            top_hi    = run_hi;
            top_score = run_score;
        end else begin
            extend_to(pos);
            promote_if_better();
        end

        // Keep the mismatch when the score pays for it, else restart after it.
        if (run_score >= w_penalty) begin
            if (run_hi < POS_TOP) begin
                run_hi++;
            end
            run_score -= w_penalty;
        end else begin
            restart   = (pos < POS_TOP) ? pos + 1 : POS_TOP;
            run_lo    = restart;
            run_hi    = restart;
            run_score = 0;
        end
        if (!it.last_item) begin
            return;
        end

        // Close the extension with the final run and the right-end bonus.
        extend_to(re);
        if (it.end_full) begin
            run_score = clip_score(run_score + w_bonus);
        end
        promote_if_better();

        res.best_start     = POS_W'(top_lo);
        res.best_end       = POS_W'(top_hi);
        res.best_sum       = SCORE_W'(top_score);
        res.trimmed        = 1'b0;
        res.emptied        = 1'b0;
        res.start_full_out = it.start_full;
        res.end_full_out   = it.end_full;
        if (!(top_lo == rs && top_hi == re)) begin
            res.trimmed = 1'b1;
            if (run_length(top_lo, top_hi) == 0) begin
                res.emptied        = 1'b1;
                res.best_sum       = '0;
                res.start_full_out = 1'b0;
                res.end_full_out   = 1'b0;
            end else begin
                if (top_lo > rs) begin
                    res.start_full_out = 1'b0;
                end
                if (top_hi < re) begin
                    res.end_full_out = 1'b0;
                end
            end
        end
        expected_trims.insert(expected_trims.size(), res);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
                     what, got, want, trims_checked, $realtime);
        end
    endtask

    // Receiver: checks each accepted result and stalls in random bursts.
    initial begin
        int           stall_left;
        t_trim_result want;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_trims.size() == 0) begin
                    report_mismatch("result with nothing pending, best_sum",
                                    out_ch.best_sum, 0);
                end else begin
                    want = expected_trims.pop_front();
                    trims_checked++;
                    trims_cut     += want.trimmed;
                    trims_emptied += want.emptied;
                    if (out_ch.best_start !== want.best_start)
                        report_mismatch("best_start", out_ch.best_start, want.best_start);
                    if (out_ch.best_end !== want.best_end)
                        report_mismatch("best_end", out_ch.best_end, want.best_end);
                    if (out_ch.best_sum !== want.best_sum)
                        report_mismatch("best_sum", out_ch.best_sum, want.best_sum);
                    if (out_ch.trimmed !== want.trimmed)
                        report_mismatch("trimmed", out_ch.trimmed, want.trimmed);
                    if (out_ch.emptied !== want.emptied)
                        report_mismatch("emptied", out_ch.emptied, want.emptied);
                    if (out_ch.start_full_out !== want.start_full_out)
                        report_mismatch("start_full_out", out_ch.start_full_out,
                                        want.start_full_out);
                    if (out_ch.end_full_out !== want.end_full_out)
                        report_mismatch("end_full_out", out_ch.end_full_out,
                                        want.end_full_out);
                end
            end
            if (receiver_stalls && stall_left == 0 && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_mismatch_item pack_mismatch(
        input int unsigned rs, input int unsigned re, input bit lf, input bit rf,
        input int unsigned pos, input bit first, input bit last);
        t_mismatch_item it;
        it.read_start   = POS_W'(rs);
        it.read_end     = POS_W'(re);
        it.start_full   = lf;
        it.end_full     = rf;
        it.mismatch_pos = POS_W'(pos);
        it.first_item   = first;
        it.last_item    = last;
        return it;
    endfunction

    // Offer one item, optionally after a short gap, and score it on acceptance.
    task automatic send_item(input t_mismatch_item it);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.read_start   <= it.read_start;
        in_ch.read_end     <= it.read_end;
        in_ch.start_full   <= it.start_full;
        in_ch.end_full     <= it.end_full;
        in_ch.mismatch_pos <= it.mismatch_pos;
        in_ch.first_item   <= it.first_item;
        in_ch.last_item    <= it.last_item;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        score_item(it);
        items_sent++;
    endtask

    // Stop sending, let every pending result come out, then let the block settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_trims.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three weights on consecutive cycles; the block must be idle.
    task automatic set_weights(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] p,
                               input logic [CFG_W-1:0] b);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MATCH_SCORE;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MISMATCH_PENALTY;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_END_BONUS;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        w_match   = m;
        w_penalty = p;
        w_bonus   = b;
        weight_sets++;
    endtask

    // One extension of up to n distinct mismatches in [rs, re), or one at rs if empty.
    task automatic send_extension(input int unsigned rs, input int unsigned re,
                                  input bit lf, input bit rf, input int unsigned n,
                                  input t_flaw flaw);
        int unsigned    spots[$];
        int unsigned    room;
        int unsigned    p;
        bit             dup;
        t_mismatch_item it;
        room = (re > rs) ? re - rs : 0;
        if (room == 0) begin
            spots.insert(spots.size(), rs);
        end else begin
            if (n > room) begin
                n = room;
            end
            while (spots.size() < n) begin
                p   = rs + $urandom_range(0, room - 1);
                dup = 1'b0;
                foreach (spots[k]) begin
                    if (spots[k] == p) dup = 1'b1;
                end
                if (!dup) spots.insert(spots.size(), p);
            end
            spots.sort();
        end
        if (flaw == FLAW_REVERSED) begin
            spots.rsort();
        end
        foreach (spots[k]) begin
            it = pack_mismatch(rs, re, lf, rf, spots[k],
                               k == 0 && flaw != FLAW_NO_FIRST,
                               k == spots.size() - 1 && flaw != FLAW_NO_LAST);
            // Later items carrying a different read interval and flags.
            if (flaw == FLAW_SHIFTED_READ && k > 0) begin
                it.read_start = POS_W'($urandom_range(0, POS_TOP));
                it.read_end   = POS_W'($urandom_range(0, POS_TOP));
                it.start_full = 1'($urandom_range(0, 1));
                it.end_full   = 1'($urandom_range(0, 1));
            end
            send_item(it);
        end
    endtask

    // A stream that starts without a first item continues from the reset state.
    task automatic test_reset_carryover();
        send_item(pack_mismatch(100, 120, 1, 1, 110, 0, 1));
        send_item(pack_mismatch(2000, 2040, 0, 1, 2010, 1, 0));
        send_item(pack_mismatch(2000, 2040, 0, 1, 2011, 0, 0));
        send_item(pack_mismatch(2000, 2040, 0, 1, 2030, 0, 1));
    endtask

    // Full read range, and positions that saturate at the top of the range.
    task automatic test_field_extremes();
        send_item(pack_mismatch(0, POS_TOP, 1, 1, 0, 1, 0));
        send_item(pack_mismatch(0, POS_TOP, 1, 1, 32768, 0, 0));
        send_item(pack_mismatch(0, POS_TOP, 1, 1, POS_TOP - 1, 0, 1));
        wait_idle();
        set_weights(10, 4, 0);
        send_item(pack_mismatch(POS_TOP - 5, POS_TOP, 0, 1, POS_TOP, 1, 1));
        wait_idle();
        set_weights(10, 255, 0);
        send_item(pack_mismatch(POS_TOP - 5, POS_TOP, 0, 1, POS_TOP, 1, 1));
        send_item(pack_mismatch(POS_TOP, POS_TOP, 1, 1, POS_TOP, 1, 1));
    endtask

    // Untrimmed, emptied, longer-wins tie and end-below-start outcomes.
    task automatic test_trim_outcomes();
        wait_idle();
        set_weights(10, 4, 0);
        send_item(pack_mismatch(1000, 1010, 1, 1, 1005, 1, 1));
        wait_idle();
        set_weights(0, 1, 0);
        send_item(pack_mismatch(500, 501, 0, 0, 500, 1, 1));
        send_item(pack_mismatch(200, 260, 1, 1, 210, 1, 0));
        send_item(pack_mismatch(200, 260, 1, 1, 230, 0, 1));
        send_item(pack_mismatch(3000, 2000, 1, 1, 2500, 1, 1));
    endtask

    // Positions that run backward, fall below the read start, or lose a last item.
    task automatic test_backward_positions();
        wait_idle();
        set_weights(3, 2, 7);
        send_item(pack_mismatch(4000, 4100, 1, 0, 4050, 1, 0));
        send_item(pack_mismatch(4000, 4100, 1, 0, 4020, 0, 0));
        send_item(pack_mismatch(4000, 4100, 1, 0, 4010, 0, 1));
        send_item(pack_mismatch(5000, 5050, 1, 1, 4990, 1, 1));
        send_item(pack_mismatch(6000, 6100, 1, 1, 6050, 1, 0));
        send_item(pack_mismatch(7000, 7010, 0, 0, 7005, 1, 1));
    endtask

    // Drive the score past its ceiling with a full-range run and a long chain of
    // right-end bonuses from items that never restart the extension.
    task automatic test_score_saturation();
        wait_idle();
        set_weights(255, 0, 255);
        send_item(pack_mismatch(0, POS_TOP, 1, 1, POS_TOP, 1, 1));
        repeat (270) begin
            send_item(pack_mismatch($urandom_range(0, POS_TOP), $urandom_range(0, POS_TOP),
                                    1'($urandom_range(0, 1)), 1, $urandom_range(0, POS_TOP),
                                    0, 1));
        end
    endtask

    // One random extension: mostly well formed, some broken, some pure noise.
    task automatic send_random_extension();
        int unsigned len;
        int unsigned rs;
        int unsigned pick;
        t_flaw       flaw;
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(0, 64);
        else if (pick < 19) len = $urandom_range(65, 3000);
        else len = $urandom_range(3001, POS_TOP);
        rs = $urandom_range(0, POS_TOP - len);
        case ($urandom_range(0, 9))
            0: flaw = FLAW_NO_FIRST;
            1: flaw = FLAW_NO_LAST;
            2: flaw = FLAW_REVERSED;
            3: flaw = FLAW_SHIFTED_READ;
            default: flaw = FLAW_NONE;
        endcase
        if ($urandom_range(0, 11) == 0) begin
            send_item(pack_mismatch($urandom_range(0, POS_TOP), $urandom_range(0, POS_TOP),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, POS_TOP), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1))));
        end else begin
            send_extension(rs, rs + len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(1, 8), flaw);
        end
    endtask

    // Random extensions under reset, zero, maximum and random weights.
    task automatic test_random_extensions();
        int goal;
        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: set_weights(1, 4, 5);
                1: set_weights(0, 0, 0);
                2: set_weights(255, 255, 255);
                3: set_weights(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                               CFG_W'($urandom_range(0, 255)));
                default: set_weights(CFG_W'($urandom_range(1, 4)),
                                     CFG_W'($urandom_range(1, 16)),
                                     CFG_W'($urandom_range(0, 20)));
            endcase
            goal = items_sent + 62;
            while (items_sent < goal) send_random_extension();
        end
    endtask

    // Back-to-back items and an always-ready receiver.
    task automatic test_back_to_back();
        int goal;
        wait_idle();
        set_weights(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 24)),
                    CFG_W'($urandom_range(0, 30)));
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        goal = items_sent + 60;
        while (items_sent < goal) begin
            send_extension(1000 * $urandom_range(0, 60), 1000 * $urandom_range(0, 60) + 40,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(1, 6), FLAW_NONE);
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_MATCH_SCORE;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.read_start   <= '0;
        in_ch.read_end     <= '0;
        in_ch.start_full   <= 1'b0;
        in_ch.end_full     <= 1'b0;
        in_ch.mismatch_pos <= '0;
        in_ch.first_item   <= 1'b0;
        in_ch.last_item    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_carryover();
        test_field_extremes();
        test_trim_outcomes();
        test_backward_positions();
        test_score_saturation();
        test_random_extensions();
        test_back_to_back();

        // Drain every pending result, then give the block time to go quiet.
        in_ch.valid <= 1'b0;
        while (expected_trims.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d mismatch items under %0d weight settings.",
                 items_sent, weight_sets);
        $display("Checked %0d intervals: %0d trimmed, %0d emptied; %0d field errors.",
                 trims_checked, trims_cut, trims_emptied, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bsit_pkg.sv
rtl/bsit_in_if.sv
rtl/bsit_out_if.sv
rtl/bsit_front.sv
rtl/bsit_back.sv
rtl/best_scoring_interval_trim_core.sv
tb/best_scoring_interval_trim_core_test.sv
